FILE: design/mmwe_pkg.sv
// Shared types and constants for the min/max window envelope block.
`default_nettype none

package mmwe_pkg;

    localparam int MAX_CHANNELS_DEF = 8;
    localparam int SAMPLE_BITS_DEF  = 16;

    // Fixed widths of the configuration port, the registers and the channel field.
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam int WIN_W      = 16;
    localparam int CCNT_W     = 4;
    localparam int CHAN_W     = 3;

    // Register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_FRAMES = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CHANNEL_COUNT = 2'd1;

    localparam logic [WIN_W-1:0]  WINDOW_FRAMES_RST = 16'd1024;
    localparam logic [CCNT_W-1:0] CHANNEL_COUNT_RST = 4'd2;

    // Handoff from the accumulator to the output serializer.
    typedef struct packed {
        logic load;
        logic final_point;
    } close_t;

endpackage

`default_nettype wire

FILE: design/mmwe_accum.sv
// Per-channel running minimum and maximum, frame and window counting.
`default_nettype none

module mmwe_accum #(
    parameter int MAX_CHANNELS = mmwe_pkg::MAX_CHANNELS_DEF,
    parameter int SAMPLE_BITS  = mmwe_pkg::SAMPLE_BITS_DEF
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                cfg_we,
    input  wire logic [mmwe_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire logic [mmwe_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  wire logic                                accept,
    input  wire logic signed [SAMPLE_BITS-1:0]       sample,
    input  wire logic                                stream_end,
    output logic [$clog2(MAX_CHANNELS+1)-1:0]        chn,
    output logic                                     win_close,
    output mmwe_pkg::close_t                         close,
    output logic signed [SAMPLE_BITS-1:0]            snap_min [MAX_CHANNELS],
    output logic signed [SAMPLE_BITS-1:0]            snap_max [MAX_CHANNELS]
);

    localparam int CIDX_W = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
    localparam int CNT_W  = $clog2(MAX_CHANNELS + 1);
    localparam logic signed [SAMPLE_BITS-1:0] SMAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    localparam logic signed [SAMPLE_BITS-1:0] SMIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

    logic [mmwe_pkg::WIN_W-1:0]  window_frames_reg;
    logic [mmwe_pkg::CCNT_W-1:0] channel_count_reg;
    logic [CIDX_W-1:0]           chan_pos_reg, chan_pos_next;
    logic [mmwe_pkg::WIN_W-1:0]  frame_count_reg, frame_count_next;
    logic signed [SAMPLE_BITS-1:0] chan_min_reg [MAX_CHANNELS];
    logic signed [SAMPLE_BITS-1:0] chan_max_reg [MAX_CHANNELS];
    logic signed [SAMPLE_BITS-1:0] pend_reg [MAX_CHANNELS];
    logic signed [SAMPLE_BITS-1:0] pend_next [MAX_CHANNELS];

    logic [mmwe_pkg::WIN_W-1:0] win;
    logic [CIDX_W-1:0]          pos;
    logic                       frame_done;
    logic [mmwe_pkg::WIN_W-1:0] fc_inc;

    always_comb
    begin
        if (channel_count_reg == '0)
            chn = CNT_W'(1);
        else if (32'(channel_count_reg) > MAX_CHANNELS)
            chn = CNT_W'(MAX_CHANNELS);
        else
            chn = CNT_W'(channel_count_reg);
        win        = (window_frames_reg == '0) ? mmwe_pkg::WIN_W'(1) : window_frames_reg;
        pos        = (CNT_W'(chan_pos_reg) < chn) ? chan_pos_reg : '0;
        frame_done = (CNT_W'(pos) + CNT_W'(1)) == chn;
        fc_inc     = frame_count_reg + mmwe_pkg::WIN_W'(frame_done);
        win_close  = (fc_inc >= win) || stream_end;
        close.load        = accept && win_close;
        close.final_point = stream_end;
        chan_pos_next     = (stream_end || frame_done) ? '0 : pos + CIDX_W'(1);
        frame_count_next  = win_close ? '0 : fc_inc;
    end

    // A frame is committed only once every channel of it has arrived.
    always_comb
    begin
        for (int i = 0; i < MAX_CHANNELS; i++)
        begin
            pend_next[i] = (CIDX_W'(i) == pos) ? sample : pend_reg[i];
            snap_min[i]  = chan_min_reg[i];
            snap_max[i]  = chan_max_reg[i];
            if (frame_done && (i < int'(chn)))
            begin
                if (pend_next[i] < chan_min_reg[i])
                    snap_min[i] = pend_next[i];
                if (pend_next[i] > chan_max_reg[i])
                    snap_max[i] = pend_next[i];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            pend_reg <= pend_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_frames_reg <= mmwe_pkg::WINDOW_FRAMES_RST;
            channel_count_reg <= mmwe_pkg::CHANNEL_COUNT_RST;
            chan_pos_reg      <= '0;
            frame_count_reg   <= '0;
            for (int i = 0; i < MAX_CHANNELS; i++)
            begin
                chan_min_reg[i] <= SMAX;
                chan_max_reg[i] <= SMIN;
            end
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                mmwe_pkg::REG_WINDOW_FRAMES: window_frames_reg <= cfg_data;
                mmwe_pkg::REG_CHANNEL_COUNT:
                    channel_count_reg <= cfg_data[mmwe_pkg::CCNT_W-1:0];
                default: ;
            endcase
            if (cfg_index == mmwe_pkg::REG_WINDOW_FRAMES ||
                cfg_index == mmwe_pkg::REG_CHANNEL_COUNT)
            begin
                chan_pos_reg    <= '0;
                frame_count_reg <= '0;
                for (int i = 0; i < MAX_CHANNELS; i++)
                begin
                    chan_min_reg[i] <= SMAX;
                    chan_max_reg[i] <= SMIN;
                end
            end
        end
        else if (accept)
        begin
            chan_pos_reg    <= chan_pos_next;
            frame_count_reg <= frame_count_next;
            for (int i = 0; i < MAX_CHANNELS; i++)
            begin
                chan_min_reg[i] <= win_close ? SMAX : snap_min[i];
                chan_max_reg[i] <= win_close ? SMIN : snap_max[i];
            end
        end
    end

endmodule

`default_nettype wire

FILE: design/mmwe_serial.sv
// Window snapshot and output register that emit one channel result per beat.
`default_nettype none

module mmwe_serial #(
    parameter int MAX_CHANNELS = mmwe_pkg::MAX_CHANNELS_DEF,
    parameter int SAMPLE_BITS  = mmwe_pkg::SAMPLE_BITS_DEF
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire mmwe_pkg::close_t                   close,
    input  wire logic [$clog2(MAX_CHANNELS+1)-1:0]  chn,
    input  wire logic signed [SAMPLE_BITS-1:0]      snap_min [MAX_CHANNELS],
    input  wire logic signed [SAMPLE_BITS-1:0]      snap_max [MAX_CHANNELS],
    output logic                                    free,
    output logic                                    out_valid,
    input  wire logic                               out_ready,
    output logic [mmwe_pkg::CHAN_W-1:0]             channel,
    output logic signed [SAMPLE_BITS-1:0]           min_value,
    output logic signed [SAMPLE_BITS-1:0]           max_value,
    output logic                                    run_last,
    output logic                                    final_point
);

    localparam int CIDX_W = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
    localparam int CNT_W  = $clog2(MAX_CHANNELS + 1);

    logic signed [SAMPLE_BITS-1:0] hold_min_reg [MAX_CHANNELS];
    logic signed [SAMPLE_BITS-1:0] hold_max_reg [MAX_CHANNELS];
    logic                          busy_reg;
    logic [CIDX_W-1:0]             idx_reg;
    logic [CNT_W-1:0]              cnt_reg;
    logic                          final_reg;

    logic                          out_valid_reg;
    logic [mmwe_pkg::CHAN_W-1:0]   channel_reg;
    logic signed [SAMPLE_BITS-1:0] min_reg, max_reg;
    logic                          run_last_reg, final_point_reg;

    logic load_out, last_load;

    always_comb
    begin
        load_out  = busy_reg && (!out_valid_reg || out_ready);
        last_load = load_out && ((CNT_W'(idx_reg) + CNT_W'(1)) == cnt_reg);
        // The snapshot can take a new window in the cycle its last entry leaves.
        free      = !busy_reg || last_load;
    end

    always_ff @(posedge clk)
    begin
        if (close.load)
        begin
            hold_min_reg <= snap_min;
            hold_max_reg <= snap_max;
            cnt_reg      <= chn;
            final_reg    <= close.final_point;
        end
        if (load_out)
        begin
            channel_reg     <= mmwe_pkg::CHAN_W'(idx_reg);
            min_reg         <= hold_min_reg[idx_reg];
            max_reg         <= hold_max_reg[idx_reg];
            run_last_reg    <= last_load;
            final_point_reg <= final_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (close.load)
            begin
                busy_reg <= 1'b1;
                idx_reg  <= '0;
            end
            else if (last_load)
                busy_reg <= 1'b0;
            else if (load_out)
                idx_reg <= idx_reg + CIDX_W'(1);

            if (load_out)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    assign out_valid   = out_valid_reg;
    assign channel     = channel_reg;
    assign min_value   = min_reg;
    assign max_value   = max_reg;
    assign run_last    = run_last_reg;
    assign final_point = final_point_reg;

endmodule

`default_nettype wire

FILE: design/minmax_window_envelope.sv
// Top level of the min/max window envelope block.
//
// The input channel takes one signed sample per beat, channels interleaved in
// rotation, with stream_end on the last sample of a stream. Each channel keeps
// a running minimum and maximum over the complete frames of a window. When a
// window closes (window_frames frames, or stream end), one result beat per
// channel leaves on the output channel in channel order, run_last set on the
// last one and final_point set when the stream end closed the window.
// The first result beat passes through the snapshot and then the output
// register, and the others follow one per cycle while the receiver takes them.
// A sample can be accepted in every cycle: a closing window copies its extremes
// into a snapshot that drains one channel per cycle while the receiver takes
// them, so input stalls only if the next window closes before the snapshot
// has drained, i.e. the snapshot's channel_count beats set the limit.
// When the receiver stalls, the output register holds its beat and the
// snapshot waits behind it. Reset clears the window, the frame position and
// the output, and loads window_frames 1024 and channel_count 2. A register
// write to either register also clears the window and the frame position.
`default_nettype none

module minmax_window_envelope #(
    parameter int MAX_CHANNELS = mmwe_pkg::MAX_CHANNELS_DEF,
    parameter int SAMPLE_BITS  = mmwe_pkg::SAMPLE_BITS_DEF
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              cfg_we,
    input  wire logic [mmwe_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [mmwe_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  wire logic                              in_valid,
    output logic                                   in_ready,
    input  wire logic signed [SAMPLE_BITS-1:0]     sample,
    input  wire logic                              stream_end,
    output logic                                   out_valid,
    input  wire logic                              out_ready,
    output logic [mmwe_pkg::CHAN_W-1:0]            channel,
    output logic signed [SAMPLE_BITS-1:0]          min_value,
    output logic signed [SAMPLE_BITS-1:0]          max_value,
    output logic                                   run_last,
    output logic                                   final_point
);

    localparam int CNT_W = $clog2(MAX_CHANNELS + 1);

    logic                          accept;
    logic [CNT_W-1:0]              chn;
    logic                          win_close;
    mmwe_pkg::close_t              close;
    logic signed [SAMPLE_BITS-1:0] snap_min [MAX_CHANNELS];
    logic signed [SAMPLE_BITS-1:0] snap_max [MAX_CHANNELS];
    logic                          free;

    // Only a beat that closes a window has to wait for the snapshot.
    assign in_ready = free || !win_close;
    assign accept   = in_valid && in_ready;

    mmwe_accum #(
        .MAX_CHANNELS (MAX_CHANNELS),
        .SAMPLE_BITS  (SAMPLE_BITS)
    ) u_accum (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .accept     (accept),
        .sample     (sample),
        .stream_end (stream_end),
        .chn        (chn),
        .win_close  (win_close),
        .close      (close),
        .snap_min   (snap_min),
        .snap_max   (snap_max)
    );

    mmwe_serial #(
        .MAX_CHANNELS (MAX_CHANNELS),
        .SAMPLE_BITS  (SAMPLE_BITS)
    ) u_serial (
        .clk         (clk),
        .rst_n       (rst_n),
        .close       (close),
        .chn         (chn),
        .snap_min    (snap_min),
        .snap_max    (snap_max),
        .free        (free),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .channel     (channel),
        .min_value   (min_value),
        .max_value   (max_value),
        .run_last    (run_last),
        .final_point (final_point)
    );

endmodule

`default_nettype wire

FILE: design/mmwe_checker.sv
// Port-level checks for the min/max window envelope, bound to the top level.
`default_nettype none

module mmwe_checker #(
    parameter int SAMPLE_BITS = mmwe_pkg::SAMPLE_BITS_DEF
) (
    input wire logic                          clk,
    input wire logic                          rst_n,
    input wire logic                          out_valid,
    input wire logic                          out_ready,
    input wire logic [mmwe_pkg::CHAN_W-1:0]   channel,
    input wire logic [SAMPLE_BITS-1:0]        min_value,
    input wire logic [SAMPLE_BITS-1:0]        max_value,
    input wire logic                          run_last,
    input wire logic                          final_point
);

    // A stalled result beat keeps its payload.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(channel) &&
        $stable(min_value) && $stable(max_value) && $stable(run_last) &&
        $stable(final_point))
        else $error("output beat changed while stalled");

    // The rest of a window follows without a gap once a beat is taken.
    a_run_gapless: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && !run_last |=> out_valid)
        else $error("gap inside a window's results");

    // Results of one window come in channel order.
    a_run_order: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && !run_last |=>
        channel == mmwe_pkg::CHAN_W'($past(channel) + mmwe_pkg::CHAN_W'(1)))
        else $error("channel order broken inside a window");

    // All results of one window agree on final_point.
    a_run_final: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && !run_last |=> final_point == $past(final_point))
        else $error("final_point changed inside a window");

endmodule

bind minmax_window_envelope mmwe_checker #(
    .SAMPLE_BITS (SAMPLE_BITS)
) u_mmwe_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .channel     (channel),
    .min_value   (min_value),
    .max_value   (max_value),
    .run_last    (run_last),
    .final_point (final_point)
);

`default_nettype wire

FILE: bench/tb_minmax_window_envelope.sv
// Self-checking testbench for minmax_window_envelope: directed table, random phases, predictor.
module tb_minmax_window_envelope;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SW             = mmwe_pkg::SAMPLE_BITS_DEF;
    localparam int CHANNELS_MAX   = mmwe_pkg::MAX_CHANNELS_DEF;
    localparam int RANDOM_ITEMS   = 240;
    localparam int SETTLE_CYCLES  = 4;
    localparam int TAIL_CYCLES    = 12;
    localparam int HOLD_CYCLES    = 300;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int REPORT_LIMIT   = 10;

    // Indexes past the register list; writes to them must change nothing.
    localparam logic [mmwe_pkg::CFG_IDX_W-1:0] REG_SPARE_2 = 2'd2;
    localparam logic [mmwe_pkg::CFG_IDX_W-1:0] REG_SPARE_3 = 2'd3;

    typedef struct packed {
        logic [mmwe_pkg::CHAN_W-1:0] channel;
        logic signed [SW-1:0]        min_v;
        logic signed [SW-1:0]        max_v;
        logic                        run_last;
        logic                        final_point;
    } point_t;

    typedef enum logic {ROW_BEAT, ROW_WRITE} row_kind_t;

    typedef struct packed {
        row_kind_t                       kind;
        logic [mmwe_pkg::CFG_IDX_W-1:0]  idx;
        logic [mmwe_pkg::CFG_DATA_W-1:0] value;
        logic                            last;
        logic                            typed;
        logic [1:0]                      n_typed;
        point_t                          p0;
        point_t                          p1;
    } row_t;

    localparam point_t NO_POINT = '0;
    localparam int N_DIRECTED = 28;

    // The index field is unused on beat rows.
    localparam row_t DIRECTED [N_DIRECTED] = '{
        // Reset setting: two channels, 1024-frame window.
        '{ROW_BEAT, '0, 16'd100, 1'b0, 1'b1, 2'd0, NO_POINT, NO_POINT},
        '{ROW_BEAT, '0, 16'hfffb, 1'b1, 1'b1, 2'd2,
          '{3'd0, 16'sd100, 16'sd100, 1'b0, 1'b1},
          '{3'd1, -16'sd5, -16'sd5, 1'b1, 1'b1}},
        // A lone sample at stream end leaves both channels without a full frame.
        '{ROW_BEAT, '0, 16'h7fff, 1'b1, 1'b1, 2'd2,
          '{3'd0, 16'sh7fff, 16'sh8000, 1'b0, 1'b1},
          '{3'd1, 16'sh7fff, 16'sh8000, 1'b1, 1'b1}},
        '{ROW_BEAT, '0, 16'h8000, 1'b0, 1'b1, 2'd0, NO_POINT, NO_POINT},
        '{ROW_BEAT, '0, 16'h7fff, 1'b0, 1'b1, 2'd0, NO_POINT, NO_POINT},
        '{ROW_BEAT, '0, 16'h7fff, 1'b0, 1'b1, 2'd0, NO_POINT, NO_POINT},
        '{ROW_BEAT, '0, 16'h8000, 1'b1, 1'b1, 2'd2,
          '{3'd0, 16'sh8000, 16'sh7fff, 1'b0, 1'b1},
          '{3'd1, 16'sh8000, 16'sh7fff, 1'b1, 1'b1}},
        // Zero window and zero channels both act as one.
        '{ROW_WRITE, mmwe_pkg::REG_WINDOW_FRAMES, 16'd0, 1'b0, 1'b0, 2'd0,
          NO_POINT, NO_POINT},
        '{ROW_WRITE, mmwe_pkg::REG_CHANNEL_COUNT, 16'd0, 1'b0, 1'b0, 2'd0,
          NO_POINT, NO_POINT},
        '{ROW_BEAT, '0, 16'd1234, 1'b0, 1'b1, 2'd1,
          '{3'd0, 16'sd1234, 16'sd1234, 1'b1, 1'b0}, NO_POINT},
        // Stream end on the sample that also fills the window: emitted once.
        '{ROW_BEAT, '0, 16'hffff, 1'b1, 1'b1, 2'd1,
          '{3'd0, -16'sd1, -16'sd1, 1'b1, 1'b1}, NO_POINT},
        // Channel count above the maximum clamps to eight.
        '{ROW_WRITE, mmwe_pkg::REG_CHANNEL_COUNT, 16'd15, 1'b0, 1'b0, 2'd0,
          NO_POINT, NO_POINT},
        '{ROW_WRITE, mmwe_pkg::REG_WINDOW_FRAMES, 16'd2, 1'b0, 1'b0, 2'd0,
          NO_POINT, NO_POINT},
        '{ROW_BEAT, '0, 16'h0001, 1'b0, 1'b0, 2'd0, NO_POINT, NO_POINT},
        '{ROW_BEAT, '0, 16'h8001, 1'b0, 1'b0, 2'd0, NO_POINT, NO_POINT},
        '{ROW_BEAT, '0, 16'h7ffe, 1'b0, 1'b0, 2'd0, NO_POINT, NO_POINT},
        // Writes past the register list must not disturb the frame in progress.
        '{ROW_WRITE, REG_SPARE_2, 16'h00ff, 1'b0, 1'b0, 2'd0, NO_POINT, NO_POINT},
        '{ROW_WRITE, REG_SPARE_3, 16'hffff, 1'b0, 1'b0, 2'd0, NO_POINT, NO_POINT},
        '{ROW_BEAT, '0, 16'h5a5a, 1'b0, 1'b0, 2'd0, NO_POINT, NO_POINT},
        '{ROW_BEAT, '0, 16'ha5a5, 1'b0, 1'b0, 2'd0, NO_POINT, NO_POINT},
        '{ROW_BEAT, '0, 16'h0000, 1'b0, 1'b0, 2'd0, NO_POINT, NO_POINT},
        '{ROW_BEAT, '0, 16'hffff, 1'b0, 1'b0, 2'd0, NO_POINT, NO_POINT},
        '{ROW_BEAT, '0, 16'h1234, 1'b1, 1'b0, 2'd0, NO_POINT, NO_POINT},
        '{ROW_WRITE, mmwe_pkg::REG_WINDOW_FRAMES, 16'hffff, 1'b0, 1'b0, 2'd0,
          NO_POINT, NO_POINT},
        '{ROW_WRITE, mmwe_pkg::REG_CHANNEL_COUNT, 16'd1, 1'b0, 1'b0, 2'd0,
          NO_POINT, NO_POINT},
        '{ROW_BEAT, '0, 16'h4000, 1'b0, 1'b0, 2'd0, NO_POINT, NO_POINT},
        '{ROW_BEAT, '0, 16'hc000, 1'b0, 1'b0, 2'd0, NO_POINT, NO_POINT},
        '{ROW_BEAT, '0, 16'h0010, 1'b1, 1'b0, 2'd0, NO_POINT, NO_POINT}
    };

    logic                            clk;
    logic                            rst_n;
    logic                            cfg_we;
    logic [mmwe_pkg::CFG_IDX_W-1:0]  cfg_index;
    logic [mmwe_pkg::CFG_DATA_W-1:0] cfg_data;
    logic                            in_valid;
    logic                            in_ready;
    logic signed [SW-1:0]            sample;
    logic                            stream_end;
    logic                            out_valid;
    logic                            out_ready;
    logic [mmwe_pkg::CHAN_W-1:0]     channel;
    logic signed [SW-1:0]            min_value;
    logic signed [SW-1:0]            max_value;
    logic                            run_last;
    logic                            final_point;

    minmax_window_envelope i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .sample      (sample),
        .stream_end  (stream_end),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .channel     (channel),
        .min_value   (min_value),
        .max_value   (max_value),
        .run_last    (run_last),
        .final_point (final_point)
    );

    // Predictor state: register copies, committed extremes, the frame being gathered.
    logic [mmwe_pkg::WIN_W-1:0]  cfg_window;
    logic [mmwe_pkg::CCNT_W-1:0] cfg_channels;
    logic signed [SW-1:0] acc_min [CHANNELS_MAX];
    logic signed [SW-1:0] acc_max [CHANNELS_MAX];
    logic signed [SW-1:0] frame_hold [CHANNELS_MAX];
    int unsigned          slot;
    int unsigned          frames_done;
    bit                   window_live;

    point_t      pending_points[$];
    int unsigned mismatches;
    int unsigned burst_left;
    int unsigned quiet_cycles;
    bit          hold_request;
    bit          hold_done;

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #10 clk = ~clk;
        end
    end

    task automatic clear_window();
        for (int i = 0; i < CHANNELS_MAX; i++)
        begin
            acc_min[i]    = {1'b0, {(SW-1){1'b1}}};
            acc_max[i]    = {1'b1, {(SW-1){1'b0}}};
            frame_hold[i] = '0;
        end
        frames_done = 0;
        window_live = 1'b0;
    endtask

    task automatic envelope_config(input logic [mmwe_pkg::CFG_IDX_W-1:0] idx,
                                   input logic [mmwe_pkg::CFG_DATA_W-1:0] data);
        case (idx)
            mmwe_pkg::REG_WINDOW_FRAMES: cfg_window = data[mmwe_pkg::WIN_W-1:0];
            mmwe_pkg::REG_CHANNEL_COUNT: cfg_channels = data[mmwe_pkg::CCNT_W-1:0];
            default: return;
        endcase
        slot = 0;
        clear_window();
    endtask

    // Advances the envelope by one sample and, if queue_points is set, queues the points it closes.
    task automatic envelope_step(input logic signed [SW-1:0] s, input logic last,
                                 input bit queue_points);
        int unsigned chn;
        int unsigned win;
        point_t      pt;
        chn = (cfg_channels == 0) ? 1 :
              (cfg_channels > CHANNELS_MAX) ? CHANNELS_MAX : int'(cfg_channels);
        win = (cfg_window == 0) ? 1 : int'(cfg_window);
        if (slot >= chn)
            slot = 0;
        frame_hold[slot] = s;
        window_live = 1'b1;
        slot++;
        if (slot >= chn)
        begin
            for (int i = 0; i < chn; i++)
            begin
                if (frame_hold[i] < acc_min[i])
                    acc_min[i] = frame_hold[i];
                if (frame_hold[i] > acc_max[i])
                    acc_max[i] = frame_hold[i];
            end
            slot = 0;
            frames_done++;
        end
        if (frames_done >= win || last)
        begin
            if (window_live && queue_points)
            begin
                for (int i = 0; i < chn; i++)
                begin
                    pt.channel     = mmwe_pkg::CHAN_W'(i);
                    pt.min_v       = acc_min[i];
                    pt.max_v       = acc_max[i];
                    pt.run_last    = (i + 1 == chn);
                    pt.final_point = last;
                    pending_points.push_back(pt);
                end
            end
            clear_window();
            if (last)
                slot = 0;
        end
    endtask

    // Sends one beat in the current burst, opening a new burst after a random gap.
    task automatic send_item(input logic [SW-1:0] s, input logic last, input bit predict);
        int unsigned gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap != 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        in_valid   <= 1'b1;
        sample     <= s;
        stream_end <= last;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        envelope_step(s, last, predict);
    endtask

    task automatic wait_idle();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (pending_points.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Leaves cfg_we high; the caller lowers it after the last write of a group.
    task automatic cfg_write(input logic [mmwe_pkg::CFG_IDX_W-1:0] idx,
                             input logic [mmwe_pkg::CFG_DATA_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        envelope_config(idx, data);
    endtask

    task automatic run_phase(input int unsigned phase_no, inout int unsigned sent);
        logic [mmwe_pkg::CFG_DATA_W-1:0] win_data;
        logic [mmwe_pkg::CFG_DATA_W-1:0] chn_data;
        logic [SW-1:0]                   s;
        logic                            last;
        int unsigned                     len;
        wait_idle();
        case ($urandom_range(0, 11))
            0:       win_data = 16'd0;
            1:       win_data = 16'hffff;
            2:       win_data = 16'($urandom);
            default: win_data = 16'($urandom_range(1, 5));
        endcase
        if ($urandom_range(0, 3) == 0)
            chn_data = {12'($urandom), 4'($urandom_range(0, 15))};
        else
            chn_data = 16'($urandom_range(1, CHANNELS_MAX));
        len = $urandom_range(8, 40);
        // One phase packs the block with short windows while the receiver holds off.
        if (phase_no == 2)
        begin
            win_data = 16'd1;
            chn_data = 16'(CHANNELS_MAX);
            len = 48;
        end
        if (phase_no == 2 || $urandom_range(0, 3) != 0)
            cfg_write(mmwe_pkg::REG_WINDOW_FRAMES, win_data);
        cfg_write(mmwe_pkg::REG_CHANNEL_COUNT, chn_data);
        if ($urandom_range(0, 3) == 0)
            cfg_write($urandom_range(0, 1) ? REG_SPARE_2 : REG_SPARE_3, 16'($urandom));
        cfg_we <= 1'b0;
        if (phase_no == 2)
            hold_request = 1'b1;
        for (int i = 0; i < len; i++)
        begin
            case ($urandom_range(0, 7))
                0:       s = 16'h8000;
                1:       s = 16'h7fff;
                default: s = 16'($urandom);
            endcase
            last = ($urandom_range(0, 19) == 0) || (i == len - 1 && $urandom_range(0, 1) == 1);
            // Once, the sender stops until every expected point has come back.
            if (phase_no == 4 && i == len / 2)
            begin
                in_valid <= 1'b0;
                do
                    @(posedge clk);
                while (pending_points.size() != 0);
            end
            send_item(s, last, 1'b1);
            sent++;
        end
    endtask

    initial
    begin : stimulus
        row_t        row;
        bit          prev_write;
        int unsigned sent;
        int unsigned phase_no;
        rst_n      <= 1'b0;
        cfg_we     <= 1'b0;
        cfg_index  <= mmwe_pkg::REG_WINDOW_FRAMES;
        cfg_data   <= '0;
        in_valid   <= 1'b0;
        sample     <= '0;
        stream_end <= 1'b0;
        mismatches   = 0;
        burst_left   = 0;
        hold_request = 1'b0;
        hold_done    = 1'b0;
        cfg_window   = mmwe_pkg::WINDOW_FRAMES_RST;
        cfg_channels = mmwe_pkg::CHANNEL_COUNT_RST;
        slot         = 0;
        clear_window();
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        prev_write = 1'b0;
        for (int r = 0; r < N_DIRECTED; r++)
        begin
            row = DIRECTED[r];
            if (row.kind == ROW_WRITE)
            begin
                if (!prev_write)
                    wait_idle();
                cfg_write(row.idx, row.value);
                if (r + 1 == N_DIRECTED || DIRECTED[r+1].kind != ROW_WRITE)
                    cfg_we <= 1'b0;
                prev_write = 1'b1;
            end
            else
            begin
                send_item(row.value, row.last, !row.typed);
                if (row.typed && row.n_typed > 0)
                    pending_points.push_back(row.p0);
                if (row.typed && row.n_typed > 1)
                    pending_points.push_back(row.p1);
                prev_write = 1'b0;
            end
        end

        sent = 0;
        phase_no = 0;
        while (sent < RANDOM_ITEMS)
        begin
            run_phase(phase_no, sent);
            phase_no++;
        end

        wait_idle();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("minmax_window_envelope verification clean");
        else
            $display("minmax_window_envelope verification failed");
        $finish;
    end

    // The receiver draws its stall pattern at random from four modes and takes one long hold-off on request.
    initial
    begin : receiver
        int unsigned cyc;
        int unsigned mode;
        bit          rdy;
        out_ready <= 1'b0;
        cyc  = 0;
        mode = 0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_request && !hold_done)
            begin
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_done = 1'b1;
            end
            if (cyc % 40 == 0)
                mode = $urandom_range(0, 3);
            case (mode)
                0:       rdy = 1'b1;
                1:       rdy = $urandom_range(0, 1);
                2:       rdy = (cyc % 4 == 0);
                default: rdy = ($urandom_range(0, 3) != 0);
            endcase
            out_ready <= rdy;
            cyc++;
        end
    end

    always @(posedge clk)
    begin : point_check
        point_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_points.size() == 0)
            begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("unexpected point: ch %0d min %0d max %0d last %0b final %0b",
                             channel, min_value, max_value, run_last, final_point);
            end
            else
            begin
                want = pending_points.pop_front();
                if (channel !== want.channel || min_value !== want.min_v ||
                    max_value !== want.max_v || run_last !== want.run_last ||
                    final_point !== want.final_point)
                begin
                    mismatches++;
                    if (mismatches <= REPORT_LIMIT)
                        $display("mismatch: exp %0d %0d %0d %0b %0b, got %0d %0d %0d %0b %0b",
                                 want.channel, want.min_v, want.max_v, want.run_last,
                                 want.final_point, channel, min_value, max_value,
                                 run_last, final_point);
                end
            end
        end
    end

    // A stretch with no accepted beat and no register write means the block is stuck.
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) || cfg_we)
            quiet_cycles <= 0;
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("minmax_window_envelope verification failed");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

endmodule
